### sv/rtt_pkg.sv
`timescale 1ns / 1ps

package rtt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH  = 128;
    localparam int ADDRESS_BITS = 32;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int LIVE_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONNECTIONS  = 1'd1;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_TOO_MANY  = 2'd1,
        VERDICT_RECONNECT = 2'd2
    } t_verdict;

    // One classified request, as it travels from front to back
    typedef struct packed {
        logic [ADDRESS_BITS-1:0] addr;
        logic [TIME_W-1:0]       now;
        logic                    over_limit;
    } t_job;

    // Slot that lies off entries after base, around the circular table
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (s >= (CNT_W + 1)'(TABLE_DEPTH))
            s = s - (CNT_W + 1)'(TABLE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

endpackage

### sv/rtt_req_if.sv
`timescale 1ns / 1ps

interface rtt_req_if;
    import rtt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ADDRESS_BITS-1:0] source_address;
    logic [TIME_W-1:0]       now_seconds;
    logic [LIVE_W-1:0]       live_from_address;

    modport source (output valid, output source_address, output now_seconds,
                    output live_from_address, input ready);
    modport sink   (input valid, input source_address, input now_seconds,
                    input live_from_address, output ready);
endinterface

### sv/rtt_rsp_if.sv
`timescale 1ns / 1ps

interface rtt_rsp_if;
    import rtt_pkg::*;

    logic     valid;
    logic     ready;
    t_verdict verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

### sv/rtt_front.sv
`timescale 1ns / 1ps

module rtt_front
    import rtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CFG_W-1:0]  i_max_connections,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [ADDRESS_BITS-1:0] i_source_address,
    input  logic [TIME_W-1:0] i_now_seconds,
    input  logic [LIVE_W-1:0] i_live_from_address,
    output logic              o_job_valid,
    output t_job              o_job,
    input  logic              i_job_pop
);

    localparam int QDEPTH = 2;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    t_job              r_queue [QDEPTH];
    logic [QP_W-1:0]   r_wp, n_wp;
    logic [QP_W-1:0]   r_rp, n_rp;
    logic [QC_W-1:0]   r_cnt, n_cnt;
    logic              push;
    t_job              new_job;

    // Classify the request against the connection limit
    always_comb begin
        new_job.addr       = i_source_address;
        new_job.now        = i_now_seconds;
        new_job.over_limit = (i_live_from_address > i_max_connections);
    end

    assign o_req_ready = (r_cnt != QC_W'(QDEPTH));
    assign push        = i_req_valid && o_req_ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_queue[r_rp];

    // Advance pointers and fill level
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push)
            n_wp = (r_wp == QP_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        if (i_job_pop)
            n_rp = (r_rp == QP_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        if (push && !i_job_pop)
            n_cnt = r_cnt + 1'b1;
        else if (!push && i_job_pop)
            n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold queued payload
    always_ff @(posedge i_clk) begin
        if (push)
            r_queue[r_wp] <= new_job;
    end

endmodule

### sv/rtt_engine.sv
`timescale 1ns / 1ps

module rtt_engine
    import rtt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_reconnect_window,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_job_pop,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_verdict         o_verdict
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_SRCH,
        ST_APPEND
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [IDX_W-1:0]  r_oldest;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_k;
    logic              r_cmp_v;
    logic              r_out_valid;
    t_verdict          r_out_verdict;

    logic [ADDRESS_BITS-1:0] addr_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]       time_mem [TABLE_DEPTH];
    logic [ADDRESS_BITS-1:0] r_addr_q;
    logic [TIME_W-1:0]       r_time_q;

    logic              out_free;
    logic              full;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_en;
    logic [TIME_W-1:0] age;

    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_job_pop   = (r_state == ST_IDLE) && i_job_valid && out_free;
    assign o_rsp_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;

    assign full   = (r_count == CNT_W'(TABLE_DEPTH));
    assign rd_idx = (r_state == ST_SRCH) ? slot_add(r_oldest, r_k) : r_oldest;
    assign wr_idx = full ? r_oldest : slot_add(r_oldest, r_count);
    assign wr_en  = (r_state == ST_APPEND);
    assign age    = r_job.now - r_time_q;

    // Table storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            addr_mem[wr_idx] <= r_job.addr;
            time_mem[wr_idx] <= r_job.now;
        end
        r_addr_q <= addr_mem[rd_idx];
        r_time_q <= time_mem[rd_idx];
    end

    // Sequencer: expire from the oldest end, search, then append when the address is not found
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_oldest      <= '0;
            r_count       <= '0;
            r_k           <= '0;
            r_cmp_v       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_verdict <= VERDICT_ACCEPT;
        end else begin
            if (r_out_valid && i_rsp_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (o_job_pop) begin
                        r_job   <= i_job;
                        r_state <= ST_EXP_RD;
                    end
                end
                ST_EXP_RD: begin
                    if (r_count == '0) begin
                        r_k     <= '0;
                        r_cmp_v <= 1'b0;
                        r_state <= ST_SRCH;
                    end else begin
                        r_state <= ST_EXP_CHK;
                    end
                end
                ST_EXP_CHK: begin
                    if (age > TIME_W'(i_reconnect_window)) begin
                        r_oldest <= slot_add(r_oldest, CNT_W'(1));
                        r_count  <= r_count - 1'b1;
                        r_state  <= ST_EXP_RD;
                    end else begin
                        r_k     <= '0;
                        r_cmp_v <= 1'b0;
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (r_cmp_v && (r_addr_q == r_job.addr)) begin
                        r_out_valid   <= 1'b1;
                        r_out_verdict <= VERDICT_RECONNECT;
                        r_state       <= ST_IDLE;
                    end else if (r_k == r_count) begin
                        r_state <= ST_APPEND;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_cmp_v <= 1'b1;
                    end
                end
                ST_APPEND: begin
                    if (full)
                        r_oldest <= slot_add(r_oldest, CNT_W'(1));
                    else
                        r_count <= r_count + 1'b1;
                    r_out_valid   <= 1'b1;
                    r_out_verdict <= r_job.over_limit ? VERDICT_TOO_MANY : VERDICT_ACCEPT;
                    r_state       <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/reconnect_throttle_table.sv
`timescale 1ns / 1ps
// Channel   Dir   Handshake      Payload
// i_req     in    valid/ready    source_address, now_seconds, live_from_address
// o_rsp     out   valid/ready    verdict
// i_cfg_*   in    write enable   i_cfg_index selects register, i_cfg_wdata value
//
// Each request runs through the table sequencer, which expires entries from
// the oldest end and then searches the rest; the single read port of the
// table serialises these reads, one entry at a time.
// Reset is synchronous and active low; the table needs no clearing pass.
// A two-entry request queue keeps taking transfers while a verdict waits in
// the output register, until it fills; o_rsp stalls also hold the sequencer.
module reconnect_throttle_table
    import rtt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rtt_req_if.sink              i_req,
    rtt_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic [CFG_W-1:0] r_reconnect_window;
    logic [CFG_W-1:0] r_max_connections;
    logic             job_valid;
    t_job             job;
    logic             job_pop;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reconnect_window <= CFG_W'(10);
            r_max_connections  <= CFG_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RECONNECT_WINDOW: r_reconnect_window <= i_cfg_wdata;
                CFG_MAX_CONNECTIONS:  r_max_connections  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rtt_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_max_connections   (r_max_connections),
        .i_req_valid         (i_req.valid),
        .o_req_ready         (i_req.ready),
        .i_source_address    (i_req.source_address),
        .i_now_seconds       (i_req.now_seconds),
        .i_live_from_address (i_req.live_from_address),
        .o_job_valid         (job_valid),
        .o_job               (job),
        .i_job_pop           (job_pop)
    );

    rtt_engine u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_reconnect_window (r_reconnect_window),
        .i_job_valid        (job_valid),
        .i_job              (job),
        .o_job_pop          (job_pop),
        .o_rsp_valid        (o_rsp.valid),
        .i_rsp_ready        (o_rsp.ready),
        .o_verdict          (o_rsp.verdict)
    );

endmodule

### dv/reconnect_throttle_table_tb.sv
`timescale 1ns / 1ps

module reconnect_throttle_table_tb;
    import rtt_pkg::*;

    // One connection attempt as offered to the block
    typedef struct packed {
        logic [ADDRESS_BITS-1:0] addr;
        logic [TIME_W-1:0]       now;
        logic [LIVE_W-1:0]       live;
    } t_attempt;

    typedef enum int {
        SEG_CHURN,
        SEG_FILL,
        SEG_NOISE
    } t_segment;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Request side drive
    logic                    req_valid = 1'b0;
    logic [ADDRESS_BITS-1:0] send_addr = '0;
    logic [TIME_W-1:0]       send_now  = '0;
    logic [LIVE_W-1:0]       send_live = '0;
    int unsigned             send_wait = 0;
    logic                    send_rush = 1'b0;

    // Response side drive
    logic        rsp_ready = 1'b0;
    int unsigned recv_wait = 0;
    logic        recv_rush = 1'b0;

    // Register write port
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RECONNECT_WINDOW;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Predicted table state and settings
    logic [ADDRESS_BITS-1:0] seen_addr [TABLE_DEPTH];
    logic [TIME_W-1:0]       seen_time [TABLE_DEPTH];
    int unsigned             oldest_slot    = 0;
    int unsigned             listed         = 0;
    logic [CFG_W-1:0]        window_setting = 16'd10;
    logic [CFG_W-1:0]        limit_setting  = 16'd4;

    t_attempt attempt_queue [$];
    t_verdict verdict_queue [$];

    int unsigned failures       = 0;
    int unsigned accepted_count = 0;
    int unsigned accept_seen    = 0;
    int unsigned too_many_seen  = 0;
    int unsigned reconnect_seen = 0;
    int unsigned reg_writes     = 0;

    rtt_req_if req_if ();
    rtt_rsp_if rsp_if ();

    assign req_if.valid             = req_valid;
    assign req_if.source_address    = send_addr;
    assign req_if.now_seconds       = send_now;
    assign req_if.live_from_address = send_live;
    assign rsp_if.ready             = rsp_ready;

    reconnect_throttle_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Expire from the oldest end, look the address up, append when new
    function automatic t_verdict judge_connection(input logic [ADDRESS_BITS-1:0] addr,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic [LIVE_W-1:0] live);
        logic [TIME_W-1:0] age;
        int unsigned       k;
        while (listed > 0) begin
            age = now - seen_time[oldest_slot];
            if (age <= TIME_W'(window_setting))
                break;
            oldest_slot = (oldest_slot + 1) % TABLE_DEPTH;
            listed--;
        end
        for (k = 0; k < listed; k++) begin
            if (seen_addr[(oldest_slot + k) % TABLE_DEPTH] == addr)
                return VERDICT_RECONNECT;
        end
        if (listed == TABLE_DEPTH) begin
            seen_addr[oldest_slot] = addr;
            seen_time[oldest_slot] = now;
            oldest_slot = (oldest_slot + 1) % TABLE_DEPTH;
        end else begin
            seen_addr[(oldest_slot + listed) % TABLE_DEPTH] = addr;
            seen_time[(oldest_slot + listed) % TABLE_DEPTH] = now;
            listed++;
        end
        return (live > LIVE_W'(limit_setting)) ? VERDICT_TOO_MANY : VERDICT_ACCEPT;
    endfunction

    function automatic void queue_attempt(input logic [ADDRESS_BITS-1:0] addr,
                                          input logic [TIME_W-1:0] now,
                                          input logic [LIVE_W-1:0] live);
        attempt_queue.push_back('{addr: addr, now: now, live: live});
    endfunction

    // Half of the counts sit around the limit, the rest anywhere in range
    function automatic logic [LIVE_W-1:0] pick_live();
        int v;
        if ($urandom_range(0, 1) == 1)
            return LIVE_W'($urandom_range(0, 65535));
        v = int'(limit_setting) + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return LIVE_W'(v);
    endfunction

    // Hold until every attempt is sent and every verdict is back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (attempt_queue.size() != 0 || req_valid || verdict_queue.size() != 0);
    endtask

    // Write both registers while the block is idle
    task automatic set_limits(input logic [CFG_W-1:0] window,
                              input logic [CFG_W-1:0] limit);
        wait_idle();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RECONNECT_WINDOW;
        cfg_wdata <= window;
        @(posedge i_clk);
        cfg_index <= CFG_MAX_CONNECTIONS;
        cfg_wdata <= limit;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        window_setting = window;
        limit_setting  = limit;
        reg_writes += 2;
        @(negedge i_clk);
    endtask

    // Request driver: present queued attempts, predict each transfer
    always @(posedge i_clk) begin : attempt_driver
        t_attempt next_item;
        logic     holding;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            send_wait <= 0;
        end else begin
            holding = req_valid && !req_if.ready;
            if (req_valid && req_if.ready) begin
                verdict_queue.push_back(judge_connection(send_addr, send_now, send_live));
                accepted_count++;
            end
            if (!holding) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    req_valid <= 1'b0;
                end else if (attempt_queue.size() != 0) begin
                    next_item = attempt_queue.pop_front();
                    send_addr <= next_item.addr;
                    send_now  <= next_item.now;
                    send_live <= next_item.live;
                    req_valid <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        send_rush = !send_rush;
                    send_wait <= send_rush ? 0 : $urandom_range(0, 10);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : verdict_monitor
        t_verdict    want;
        int unsigned hold;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
            recv_wait <= 0;
        end else if (rsp_ready && rsp_if.valid) begin
            if (verdict_queue.size() == 0) begin
                $error("verdict %0d arrived with nothing pending", rsp_if.verdict);
                failures++;
            end else begin
                want = verdict_queue.pop_front();
                if (rsp_if.verdict !== want) begin
                    $error("verdict: expected %0d (%s), got %0d",
                           want, want.name(), rsp_if.verdict);
                    failures++;
                end
            end
            case (rsp_if.verdict)
                VERDICT_ACCEPT:    accept_seen++;
                VERDICT_TOO_MANY:  too_many_seen++;
                VERDICT_RECONNECT: reconnect_seen++;
                default: ;
            endcase
            if ($urandom_range(0, 15) == 0)
                recv_rush = !recv_rush;
            hold = recv_rush ? 0 : $urandom_range(0, 10);
            recv_wait <= hold;
            rsp_ready <= (hold == 0);
        end else if (!rsp_ready) begin
            if (recv_wait <= 1)
                rsp_ready <= 1'b1;
            if (recv_wait != 0)
                recv_wait <= recv_wait - 1;
        end
    end

    initial begin : stimulus
        logic [ADDRESS_BITS-1:0] pool [6];
        logic [ADDRESS_BITS-1:0] base_addr;
        logic [TIME_W-1:0]       clock_s;
        logic [CFG_W-1:0]        window;
        logic [CFG_W-1:0]        limit;
        t_segment                kind;
        int unsigned             random_sent;
        int unsigned             n;
        int unsigned             i;
        int unsigned             r;

        random_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: window 10, limit 4
        queue_attempt(32'h0000_0000, 32'd0, 16'd0);
        queue_attempt(32'h0000_0000, 32'd5, 16'd0);          // listed again
        queue_attempt(32'hFFFF_FFFF, 32'd10, 16'hFFFF);      // far over the limit
        queue_attempt(32'h0000_0000, 32'd10, 16'd4);         // age equals window
        queue_attempt(32'h0000_0000, 32'd11, 16'd5);         // aged out, one over limit
        queue_attempt(32'h0000_0001, 32'd3, 16'd4);          // time went backwards
        queue_attempt(32'h0000_0002, 32'hFFFF_FFFF, 16'd0);
        queue_attempt(32'h0000_0002, 32'd5, 16'd0);          // time wrapped, still listed
        queue_attempt(32'h0000_0003, 32'd20, 16'd0);
        queue_attempt(32'h0000_0004, 32'd30, 16'd0);
        queue_attempt(32'h0000_0004, 32'd25, 16'd0);         // younger entry kept behind
        queue_attempt(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
        queue_attempt(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);

        // Zero window and zero limit
        set_limits(16'd0, 16'd0);
        queue_attempt(32'h0000_0005, 32'd100, 16'd0);
        queue_attempt(32'h0000_0005, 32'd100, 16'd1);        // age zero survives
        queue_attempt(32'h0000_0006, 32'd100, 16'd1);
        queue_attempt(32'h0000_0005, 32'd101, 16'd0);        // any nonzero age expires

        // Widest window and highest limit
        set_limits(16'hFFFF, 16'hFFFF);
        queue_attempt(32'h0000_0007, 32'h8000_0000, 16'hFFFF);
        queue_attempt(32'h0000_0007, 32'h8000_FFFF, 16'd0);  // age at the window
        queue_attempt(32'h0000_0008, 32'h8001_0000, 16'd0);  // one past the window
        queue_attempt(32'h0000_0007, 32'h8001_0000, 16'hFFFE);

        // Random segments, the first one filling the table
        while (random_sent < 500) begin
            if (random_sent == 0) begin
                kind = SEG_FILL;
            end else begin
                r = $urandom_range(0, 5);
                kind = (r < 4) ? SEG_CHURN : ((r == 4) ? SEG_FILL : SEG_NOISE);
            end
            case (kind)
                SEG_CHURN: begin
                    r = $urandom_range(0, 5);
                    window = (r == 0) ? 16'd0 : ((r == 1) ? 16'hFFFF :
                             CFG_W'($urandom_range(1, 20)));
                    r = $urandom_range(0, 5);
                    limit = (r == 0) ? 16'd0 : ((r == 1) ? 16'hFFFF :
                            CFG_W'($urandom_range(0, 8)));
                    set_limits(window, limit);
                    for (i = 0; i < 6; i++)
                        pool[i] = $urandom;
                    if ($urandom_range(0, 3) == 0)
                        pool[0] = '0;
                    if ($urandom_range(0, 3) == 0)
                        pool[1] = '1;
                    r = $urandom_range(0, 3);
                    clock_s = (r == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 60) :
                              ((r == 1) ? TIME_W'($urandom_range(0, 100)) : $urandom);
                    n = $urandom_range(30, 60);
                    for (i = 0; i < n; i++) begin
                        r = $urandom_range(0, 99);
                        if (r < 5)
                            clock_s -= $urandom_range(1, 1000);
                        else if (r < 10)
                            clock_s += $urandom_range(100, 100000);
                        else
                            clock_s += $urandom_range(0, 3);
                        queue_attempt(($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)]
                                                                 : $urandom,
                                      clock_s, pick_live());
                    end
                    random_sent += n;
                end
                SEG_FILL: begin
                    window = ($urandom_range(0, 1) == 1) ? 16'hFFFF
                                                         : CFG_W'($urandom_range(2000, 65535));
                    limit = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom_range(0, 8))
                                                        : CFG_W'($urandom_range(0, 65535));
                    set_limits(window, limit);
                    base_addr = $urandom;
                    clock_s = $urandom;
                    n = TABLE_DEPTH + $urandom_range(1, 20);
                    // Distinct addresses overflow the table
                    for (i = 0; i < n; i++)
                        queue_attempt(base_addr + i, clock_s + i / 16, pick_live());
                    // Revisit: overwritten ones come back new, the rest are listed
                    for (i = 0; i < 24; i++)
                        queue_attempt(base_addr + $urandom_range(0, n - 1),
                                      clock_s + n / 16, pick_live());
                    random_sent += n + 24;
                end
                default: begin
                    set_limits(CFG_W'($urandom_range(0, 65535)),
                               CFG_W'($urandom_range(0, 65535)));
                    for (i = 0; i < 30; i++)
                        queue_attempt($urandom, $urandom, LIVE_W'($urandom_range(0, 65535)));
                    random_sent += 30;
                end
            endcase
        end

        // Drain, then allow for a stray verdict
        wait_idle();
        repeat (300) @(posedge i_clk);
        if (verdict_queue.size() != 0) begin
            $error("%0d predicted verdicts never arrived", verdict_queue.size());
            failures++;
        end
        $display("Sent %0d attempts over %0d register writes, table overflow included",
                 accepted_count, reg_writes);
        $display("Verdicts seen: %0d accept, %0d over limit, %0d recent reconnect",
                 accept_seen, too_many_seen, reconnect_seen);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin : watchdog
        #2_000_000;
        $display("Run timed out with %0d verdicts pending", verdict_queue.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

### reconnect_throttle_table.f
sv/rtt_pkg.sv
sv/rtt_req_if.sv
sv/rtt_rsp_if.sv
sv/rtt_front.sv
sv/rtt_engine.sv
sv/reconnect_throttle_table.sv
dv/reconnect_throttle_table_tb.sv
